// ===== rtl/core/chaocipher_codec_top_defines.svh =====
// assertion macros for the chaocipher codec
`ifndef CHAOCIPHER_CODEC_TOP_DEFINES_SVH
`define CHAOCIPHER_CODEC_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, idle during reset
`define CHC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, idle during reset
`define CHC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CHC_ASSERT_SAME(lbl, ante, cons, msg)
`define CHC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/chc_pkg.sv =====
// shared types and constants for the chaocipher codec
`timescale 1ns / 1ps
`default_nettype none

package chc_pkg;

    localparam int SYM_W = 8;
    localparam int POS_W = 5;

    // request type codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TEXT = 1'b1;

    // alphabet select codes for loads
    localparam logic ALPHA_CIPHER = 1'b0;
    localparam logic ALPHA_PLAIN  = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load_we;
        logic capture;
        logic select;
        logic permute;
    } chc_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic found;
    } chc_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/chc_ctrl.sv =====
// controller state machine for the chaocipher codec
`timescale 1ns / 1ps
`default_nettype none
`include "chaocipher_codec_top_defines.svh"

module chc_ctrl
    import chc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire logic      req_type,
    output logic           out_valid,
    input  wire logic      out_ready,
    output chc_cmd_t       cmd,
    input  wire chc_sts_t  sts
);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_SELECT  = 3'b010,
        ST_PERMUTE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_xfer;
    logic   out_free;

    // handshake terms
    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // commands to the datapath
    always_comb
    begin
        cmd.load_we = in_xfer && (req_type == REQ_LOAD);
        cmd.capture = in_xfer && (req_type == REQ_TEXT);
        cmd.select  = (state_reg == ST_SELECT) && out_free;
        cmd.permute = (state_reg == ST_PERMUTE);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                if (out_free)
                begin
                    state_next = sts.found ? ST_PERMUTE : ST_IDLE;
                end
            end
            ST_PERMUTE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.select)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `CHC_ASSERT_SAME(a_permute_after_hit, state_reg == ST_PERMUTE, $past(sts.found), "permute without a match")
    `CHC_ASSERT_SAME(a_result_from_select, $rose(out_valid_reg), $past(state_reg == ST_SELECT), "result not from select")
    `CHC_ASSERT_NEXT(a_text_goes_select, cmd.capture, state_reg == ST_SELECT, "text transfer did not start lookup")

endmodule

`default_nettype wire

// ===== rtl/core/chc_datapath.sv =====
// alphabet registers, match, output register and permutation for the chaocipher codec
`timescale 1ns / 1ps
`default_nettype none
`include "chaocipher_codec_top_defines.svh"

module chc_datapath
    import chc_pkg::*;
#(
    parameter int ALPHA_SIZE = 26,
    parameter int NADIR_POS  = 13
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic             cfg_wdata,
    input  wire chc_cmd_t         cmd,
    output chc_sts_t              sts,
    input  wire logic             alphabet_sel,
    input  wire logic [POS_W-1:0] entry_pos,
    input  wire logic [SYM_W-1:0] symbol,
    output logic      [SYM_W-1:0] out_symbol,
    output logic                  not_found
);

    localparam int IDX_W = $clog2(ALPHA_SIZE);
    localparam int NADIR = (NADIR_POS >= ALPHA_SIZE) ? ALPHA_SIZE - 1 : NADIR_POS;

    logic                  decipher_mode_reg;
    logic [SYM_W-1:0]      cipher_reg [ALPHA_SIZE];
    logic [SYM_W-1:0]      plain_reg  [ALPHA_SIZE];
    logic [ALPHA_SIZE-1:0] hit_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [SYM_W-1:0]      out_symbol_reg;
    logic                  not_found_reg;

    logic [ALPHA_SIZE-1:0] hit_next;
    logic [ALPHA_SIZE-1:0] lowest;
    logic                  found;
    logic [IDX_W-1:0]      idx_next;
    logic [SYM_W-1:0]      sel_symbol;
    logic [SYM_W-1:0]      cipher_perm [ALPHA_SIZE];
    logic [SYM_W-1:0]      plain_perm  [ALPHA_SIZE];

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decipher_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            decipher_mode_reg <= cfg_wdata;
        end
    end

    // parallel compare against the source alphabet
    always_comb
    begin
        for (int i = 0; i < ALPHA_SIZE; i++)
        begin
            hit_next[i] = decipher_mode_reg ? (cipher_reg[i] == symbol)
                                            : (plain_reg[i] == symbol);
        end
    end

    // lowest matching position and the symbol opposite it
    always_comb
    begin
        lowest     = hit_reg & (~hit_reg + ALPHA_SIZE'(1));
        found      = |hit_reg;
        idx_next   = '0;
        sel_symbol = '0;
        for (int i = 0; i < ALPHA_SIZE; i++)
        begin
            idx_next   = idx_next | (lowest[i] ? IDX_W'(i) : '0);
            sel_symbol = sel_symbol
                       | ({SYM_W{lowest[i]}}
                          & (decipher_mode_reg ? plain_reg[i] : cipher_reg[i]));
        end
    end

    assign sts.found  = found;
    assign out_symbol = out_symbol_reg;
    assign not_found  = not_found_reg;

    // rotate both alphabets by the found position, then move the entry to the nadir
    always_comb
    begin
        logic [SYM_W-1:0] stg [IDX_W+1][ALPHA_SIZE];
        logic [SYM_W-1:0] prot [ALPHA_SIZE];
        logic [SYM_W-1:0] crot [ALPHA_SIZE];
        // cipher alphabet through the log rotator
        for (int i = 0; i < ALPHA_SIZE; i++)
        begin
            stg[0][i] = cipher_reg[i];
        end
        for (int b = 0; b < IDX_W; b++)
        begin
            for (int i = 0; i < ALPHA_SIZE; i++)
            begin
                stg[b+1][i] = idx_reg[b] ? stg[b][(i + (1 << b)) % ALPHA_SIZE] : stg[b][i];
            end
        end
        for (int i = 0; i < ALPHA_SIZE; i++)
        begin
            crot[i] = stg[IDX_W][i];
        end
        // plain alphabet through the same rotator, one step further
        for (int i = 0; i < ALPHA_SIZE; i++)
        begin
            stg[0][i] = plain_reg[i];
        end
        for (int b = 0; b < IDX_W; b++)
        begin
            for (int i = 0; i < ALPHA_SIZE; i++)
            begin
                stg[b+1][i] = idx_reg[b] ? stg[b][(i + (1 << b)) % ALPHA_SIZE] : stg[b][i];
            end
        end
        for (int i = 0; i < ALPHA_SIZE; i++)
        begin
            prot[i] = stg[IDX_W][(i + 1) % ALPHA_SIZE];
        end
        // zenith plus one to nadir on cipher, zenith plus two on plain
        for (int i = 0; i < ALPHA_SIZE; i++)
        begin
            if (i == NADIR)
            begin
                cipher_perm[i] = crot[1];
                plain_perm[i]  = prot[2];
            end
            else
            begin
                cipher_perm[i] = (i >= 1 && i < NADIR) ? crot[(i + 1) % ALPHA_SIZE] : crot[i];
                plain_perm[i]  = (i >= 2 && i < NADIR) ? prot[(i + 1) % ALPHA_SIZE] : prot[i];
            end
        end
    end

    // alphabet registers: key loads and permutation
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ALPHA_SIZE; i++)
        begin
            if (cmd.permute)
            begin
                cipher_reg[i] <= cipher_perm[i];
                plain_reg[i]  <= plain_perm[i];
            end
            else if (cmd.load_we && (int'(entry_pos) == i))
            begin
                if (alphabet_sel == ALPHA_CIPHER)
                begin
                    cipher_reg[i] <= symbol;
                end
                else
                begin
                    plain_reg[i] <= symbol;
                end
            end
        end
    end

    // match vector, position and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            hit_reg <= hit_next;
        end
        if (cmd.select)
        begin
            idx_reg        <= idx_next;
            out_symbol_reg <= found ? sel_symbol : '0;
            not_found_reg  <= !found;
        end
    end

    `CHC_ASSERT_NEXT(a_miss_result, cmd.select && !found, not_found_reg && (out_symbol_reg == '0), "miss result not flagged")

endmodule

`default_nettype wire

// ===== rtl/core/chaocipher_codec_top.sv =====
// top level of the chaocipher codec
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | in_valid / in_ready   | req_type, alphabet_sel, entry_pos, symbol
//  output   | out_valid / out_ready | out_symbol, not_found
//  config   | cfg_we                | cfg_wdata (decipher mode)
//
//  a key-load transfer writes one alphabet entry and gives no result
//  a text transfer steps through transfer, select and permute, skipping permute when not found;
//  the permute step rewrites both alphabets, and no new request is taken before it is done
//  select waits while the output register still holds an untaken result
//  alphabet entries are undefined after reset until loaded; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module chaocipher_codec_top
    import chc_pkg::*;
#(
    parameter int ALPHA_SIZE = 26,
    parameter int NADIR_POS  = 13
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic             cfg_wdata,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             req_type,
    input  wire logic             alphabet_sel,
    input  wire logic [POS_W-1:0] entry_pos,
    input  wire logic [SYM_W-1:0] symbol,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [SYM_W-1:0] out_symbol,
    output logic                  not_found
);

    chc_cmd_t cmd;
    chc_sts_t sts;

    // sequencing
    chc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // alphabets and lookup
    chc_datapath #(
        .ALPHA_SIZE (ALPHA_SIZE),
        .NADIR_POS  (NADIR_POS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .sts          (sts),
        .alphabet_sel (alphabet_sel),
        .entry_pos    (entry_pos),
        .symbol       (symbol),
        .out_symbol   (out_symbol),
        .not_found    (not_found)
    );

endmodule

`default_nettype wire

// ===== sim/chaocipher_codec_checker.sv =====
// transfer checker for the chaocipher codec: tracks both alphabets and compares every result
`timescale 1ns / 1ps

module chaocipher_codec_checker
    import chc_pkg::*;
#(
    parameter int ALPHA_SIZE = 26,
    parameter int NADIR_POS  = 13
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic             req_type,
    input  logic             alphabet_sel,
    input  logic [POS_W-1:0] entry_pos,
    input  logic [SYM_W-1:0] symbol,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [SYM_W-1:0] out_symbol,
    input  logic             not_found,
    output int               err_count,
    output int               pending,
    output int               load_count,
    output int               text_count,
    output int               miss_count
);

    typedef logic [ALPHA_SIZE-1:0][SYM_W-1:0] alphabet_t;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             miss;
    } letter_t;

    alphabet_t left_abc;    // cipher alphabet
    alphabet_t right_abc;   // plain alphabet
    logic      decipher;
    letter_t   owed_letters[$];
    letter_t   taken;
    int        result_count;

    // lowest position holding s, or -1 when absent
    function automatic int find_letter(alphabet_t abc, logic [SYM_W-1:0] s);
        int i;
        for (i = 0; i < ALPHA_SIZE; i++)
        begin
            if (abc[i] == s)
                return i;
        end
        return -1;
    endfunction

    // rotate left by shift, then pull the entry at take along to the nadir
    function automatic alphabet_t twist(alphabet_t abc, int shift, int take);
        alphabet_t        r;
        logic [SYM_W-1:0] held;
        int               nadir;
        int               i;
        nadir = (NADIR_POS >= ALPHA_SIZE) ? ALPHA_SIZE - 1 : NADIR_POS;
        for (i = 0; i < ALPHA_SIZE; i++)
            r[i] = abc[(i + shift) % ALPHA_SIZE];
        held = r[take];
        if (take < nadir)
        begin
            for (i = take; i < nadir; i++)
                r[i] = r[i + 1];
        end
        else
        begin
            for (i = take; i > nadir; i--)
                r[i] = r[i - 1];
        end
        r[nadir] = held;
        return r;
    endfunction

    // expected output of one text symbol, and the zenith/nadir step that follows
    task automatic predict_text(input logic [SYM_W-1:0] s);
        letter_t res;
        int      hit;
        hit = find_letter(decipher ? left_abc : right_abc, s);
        if (hit < 0)
        begin
            res.sym  = '0;
            res.miss = 1'b1;
            miss_count++;
        end
        else
        begin
            res.sym   = decipher ? right_abc[hit] : left_abc[hit];
            res.miss  = 1'b0;
            left_abc  = twist(left_abc, hit, 1);
            right_abc = twist(right_abc, hit + 1, 2);
        end
        owed_letters = {owed_letters, res};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_abc     = '0;
            right_abc    = '0;
            decipher     = 1'b0;
            owed_letters.delete();
            err_count    = 0;
            load_count   = 0;
            text_count   = 0;
            miss_count   = 0;
            result_count = 0;
        end
        else
        begin
            if (cfg_we)
                decipher = cfg_wdata;

            // result transfer against the oldest owed letter
            if (out_valid && out_ready)
            begin
                if (owed_letters.size() == 0)
                begin
                    if (err_count < 10)
                        $display("unexpected result: symbol %02h not_found %0b",
                                 out_symbol, not_found);
                    err_count++;
                end
                else
                begin
                    taken = owed_letters.pop_front();
                    if (out_symbol !== taken.sym || not_found !== taken.miss)
                    begin
                        if (err_count < 10)
                            $display("result %0d: expected symbol %02h not_found %0b, got %02h %0b",
                                     result_count, taken.sym, taken.miss, out_symbol, not_found);
                        err_count++;
                    end
                end
                result_count++;
            end

            // request transfer: key write or text symbol
            if (in_valid && in_ready)
            begin
                if (req_type == REQ_LOAD)
                begin
                    load_count++;
                    if (entry_pos < ALPHA_SIZE)
                    begin
                        if (alphabet_sel == ALPHA_CIPHER)
                            left_abc[entry_pos] = symbol;
                        else
                            right_abc[entry_pos] = symbol;
                    end
                end
                else
                begin
                    text_count++;
                    predict_text(symbol);
                end
            end
        end
        pending = owed_letters.size();
    end

endmodule

// ===== sim/chaocipher_codec_top_test.sv =====
// testbench top for the chaocipher codec: stimulus, handshake timing and verdict
`timescale 1ns / 1ps

module chaocipher_codec_top_test;
    import chc_pkg::*;

    localparam int   ALPHA         = 26;
    localparam int   NADIR         = 13;
    localparam int   IDLE_LIMIT    = 1000;
    localparam int   SETTLE_CYCLES = 6;
    localparam int   POS_MAX       = (1 << POS_W) - 1;
    localparam int   SYM_MAX       = (1 << SYM_W) - 1;
    localparam logic MODE_ENCIPHER = 1'b0;
    localparam logic MODE_DECIPHER = 1'b1;

    typedef logic [ALPHA-1:0][SYM_W-1:0] key_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             cfg_we       = 1'b0;
    logic             cfg_wdata    = 1'b0;
    logic             in_valid     = 1'b0;
    logic             in_ready;
    logic             req_type     = REQ_LOAD;
    logic             alphabet_sel = ALPHA_CIPHER;
    logic [POS_W-1:0] entry_pos    = '0;
    logic [SYM_W-1:0] symbol       = '0;
    logic             out_valid;
    logic             out_ready    = 1'b0;
    logic [SYM_W-1:0] out_symbol;
    logic             not_found;

    int   err_count;
    int   pending;
    int   load_count;
    int   text_count;
    int   miss_count;
    int   idle_cycles = 0;
    int   stall_left  = 0;
    bit   calm        = 1'b0;
    logic cur_mode    = MODE_ENCIPHER;
    key_t left_key;
    key_t right_key;

    always #6 clk = ~clk;

    chaocipher_codec_top #(
        .ALPHA_SIZE (ALPHA),
        .NADIR_POS  (NADIR)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .alphabet_sel (alphabet_sel),
        .entry_pos    (entry_pos),
        .symbol       (symbol),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_symbol   (out_symbol),
        .not_found    (not_found)
    );

    chaocipher_codec_checker #(
        .ALPHA_SIZE (ALPHA),
        .NADIR_POS  (NADIR)
    ) codec_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .alphabet_sel (alphabet_sel),
        .entry_pos    (entry_pos),
        .symbol       (symbol),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_symbol   (out_symbol),
        .not_found    (not_found),
        .err_count    (err_count),
        .pending      (pending),
        .load_count   (load_count),
        .text_count   (text_count),
        .miss_count   (miss_count)
    );

    // mostly short gaps, now and then a long one, none while calm
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < 25)
        begin
            stall_left = pick_gap();
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("no transfer for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // one request transfer; returns just after the accepting edge
    task automatic send_item(input logic rt, input logic sel,
                             input logic [POS_W-1:0] pos, input logic [SYM_W-1:0] sym);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= rt;
        alphabet_sel <= sel;
        entry_pos    <= pos;
        symbol       <= sym;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // whole key into one alphabet, optionally shuffled with stray out-of-range writes
    task automatic load_key(input logic sel, input key_t key, input bit shuffled);
        int order[ALPHA];
        int i;
        int j;
        int t;
        for (i = 0; i < ALPHA; i++)
            order[i] = i;
        if (shuffled)
        begin
            for (i = ALPHA - 1; i > 0; i--)
            begin
                j        = $urandom_range(0, i);
                t        = order[i];
                order[i] = order[j];
                order[j] = t;
            end
        end
        for (i = 0; i < ALPHA; i++)
        begin
            if (shuffled && $urandom_range(0, 15) == 0)
                send_item(REQ_LOAD, 1'($urandom_range(0, 1)),
                          POS_W'($urandom_range(ALPHA, POS_MAX)),
                          SYM_W'($urandom_range(0, SYM_MAX)));
            send_item(REQ_LOAD, sel, POS_W'(order[i]), key[order[i]]);
        end
    endtask

    // distinct random bytes, optionally with one repeated symbol
    function automatic key_t random_key(bit with_dup);
        logic [SYM_W-1:0] pool[1 << SYM_W];
        logic [SYM_W-1:0] t;
        key_t             k;
        int               i;
        int               j;
        for (i = 0; i <= SYM_MAX; i++)
            pool[i] = SYM_W'(i);
        for (i = 0; i < ALPHA; i++)
        begin
            j       = $urandom_range(i, SYM_MAX);
            t       = pool[i];
            pool[i] = pool[j];
            pool[j] = t;
            k[i]    = pool[i];
        end
        if (with_dup)
            k[$urandom_range(1, ALPHA - 1)] = k[$urandom_range(0, ALPHA - 2)];
        return k;
    endfunction

    // mostly a symbol from the current source alphabet, otherwise any byte
    function automatic logic [SYM_W-1:0] pick_text();
        if ($urandom_range(0, 99) < 85)
            return (cur_mode == MODE_DECIPHER) ? left_key[$urandom_range(0, ALPHA - 1)]
                                               : right_key[$urandom_range(0, ALPHA - 1)];
        return SYM_W'($urandom_range(0, SYM_MAX));
    endfunction

    task automatic send_text(input logic [SYM_W-1:0] sym);
        send_item(REQ_TEXT, 1'($urandom_range(0, 1)), POS_W'($urandom_range(0, POS_MAX)), sym);
    endtask

    // stop sending and wait until every owed result has come back
    task automatic drain(input int extra);
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_mode(input logic m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_mode  = m;
    endtask

    initial
    begin
        int i;
        int phase;
        int n;
        int r;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed key: both alphabets hold 0 and 255, each has one repeated symbol
        for (i = 0; i < ALPHA; i++)
        begin
            left_key[i]  = SYM_W'(255 - i * 9);
            right_key[i] = SYM_W'(i * 9);
        end
        left_key[ALPHA - 1]  = 8'h00;
        right_key[ALPHA - 1] = 8'hFF;
        left_key[22]         = left_key[9];
        right_key[17]        = right_key[5];
        load_key(ALPHA_CIPHER, left_key, 1'b0);
        load_key(ALPHA_PLAIN, right_key, 1'b0);

        // out-of-range writes that must be dropped
        send_item(REQ_LOAD, ALPHA_PLAIN, POS_W'(POS_MAX), 8'h01);
        send_item(REQ_LOAD, ALPHA_CIPHER, POS_W'(ALPHA), 8'h02);
        drain(SETTLE_CYCLES);
        set_mode(MODE_ENCIPHER);

        // encipher: last then first position, repeated symbol, absent symbols
        send_item(REQ_TEXT, ALPHA_PLAIN, POS_W'(POS_MAX), 8'hFF);
        send_item(REQ_TEXT, ALPHA_CIPHER, '0, 8'h00);
        send_text(right_key[5]);
        send_text(8'h01);
        send_text(8'h64);
        send_text(right_key[5]);
        drain(SETTLE_CYCLES);
        set_mode(MODE_DECIPHER);

        // decipher: extremes, repeated symbol, absent, then a fresh entry at the zenith
        send_text(8'hFF);
        send_text(8'h00);
        send_text(left_key[9]);
        send_text(8'h02);
        send_item(REQ_LOAD, ALPHA_CIPHER, '0, 8'h03);
        send_text(8'h03);

        // random phases with fresh keys, modes and handshake pressure
        for (phase = 0; phase < 6; phase++)
        begin
            drain(SETTLE_CYCLES);
            calm = (phase == 2) || ($urandom_range(0, 3) == 0);
            if (phase < 2)
                set_mode(phase == 0 ? MODE_ENCIPHER : MODE_DECIPHER);
            else
                set_mode(1'($urandom_range(0, 1)));
            if (phase % 2 == 0 || $urandom_range(0, 2) == 0)
            begin
                left_key  = random_key($urandom_range(0, 3) == 0);
                right_key = random_key($urandom_range(0, 3) == 0);
                load_key(ALPHA_CIPHER, left_key, 1'b1);
                load_key(ALPHA_PLAIN, right_key, 1'b1);
            end
            for (n = 0; n < 25; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    send_item(REQ_LOAD, 1'($urandom_range(0, 1)),
                              POS_W'($urandom_range(ALPHA, POS_MAX)),
                              SYM_W'($urandom_range(0, SYM_MAX)));
                else if (r < 8)
                    send_item(REQ_LOAD, 1'($urandom_range(0, 1)),
                              POS_W'($urandom_range(0, ALPHA - 1)),
                              SYM_W'($urandom_range(0, SYM_MAX)));
                else
                    send_text(pick_text());
            end
        end

        drain(SETTLE_CYCLES * 2);
        $display("covered %0d key writes and %0d text symbols, %0d of them not in the alphabet,",
                 load_count, text_count, miss_count);
        $display("in both directions, with and without back-pressure on either side");
        if (err_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/chc_pkg.sv
rtl/core/chc_ctrl.sv
rtl/core/chc_datapath.sv
rtl/core/chaocipher_codec_top.sv
sim/chaocipher_codec_checker.sv
sim/chaocipher_codec_top_test.sv
